### rtl/tilp_pkg.sv
// Package for the task and interrupt load profiler: types, codes, constants.
`default_nettype none
package tilp_pkg;
  localparam int unsigned Records = 32;
  localparam int unsigned IdxW = 5;
  // record word: start_stamp, end_stamp, start_gap, idle_gap, max_duration,
  // accumulated_run, record_load_peak, start_seen, end_seen
  localparam int unsigned RecW = 32 * 6 + 16 + 2;

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0, OP_END = 3'd1, OP_IRQ = 3'd2, OP_CLOSE = 3'd3, OP_PEAKS = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0, KIND_LOAD = 2'd1, KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_CPT = 2'd0, CFG_TMASK = 2'd1, CFG_IMASK = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVRD, ST_EVWR, ST_CLRD, ST_CLMUL, ST_CLDIV, ST_CLWR,
    ST_TDIV, ST_IDIV, ST_SUM, ST_PEAK
  } state_e;

  typedef struct packed {
    logic [31:0] start_stamp;
    logic [31:0] end_stamp;
    logic [31:0] start_gap;
    logic [31:0] idle_gap;
    logic [31:0] max_duration;
    logic [31:0] accumulated_run;
    logic [15:0] record_load_peak;
    logic        start_seen;
    logic        end_seen;
  } rec_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  record_index;
    logic [31:0] counter_now;
    logic [31:0] start_count;
    logic [31:0] system_tick;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  out_index;
    logic [31:0] measured_time;
    logic [31:0] peak_time;
    logic [31:0] start_interval;
    logic [31:0] idle_interval;
    logic [15:0] load;
    logic [15:0] load_peak;
    logic [15:0] irq_load;
    logic [15:0] irq_load_peak;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

### rtl/tilp_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module tilp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/tilp_div.sv
// Serial restoring divider: 52-bit dividend by 32-bit divisor, saturated Q1.15 result.
`default_nettype none
module tilp_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [51:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [15:0]      quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [51:0] num_q, num_d;
  logic [51:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] sh;
  logic        ge;
  logic [51:0] quo_s;

  // done_o and quot_o depend on registered state only, never on go_i
  assign sh     = {rem_q[31:0], num_q[51]};
  assign ge     = (sh >= {1'b0, den_q});
  assign quo_s  = {quo_q[50:0], ge};
  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = (quo_s[51:16] != '0) ? 16'hFFFF : quo_s[15:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd52;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[50:0], 1'b0};
      rem_d = ge ? (sh - {1'b0, den_q}) : sh;
      quo_d = quo_s;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

### rtl/task_interrupt_load_profiler.sv
// Top level of the task and interrupt load profiler.
// Channel  | Direction | Handshake          | Payload
// request  | in        | start_i / busy_o   | req_i (tilp_pkg::req_t)
// result   | out       | res_valid_o        | res_o (tilp_pkg::res_t)
// config   | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
// Event requests hold busy_o through a record RAM read state and a write-back
// state; the result follows in the next cycle. Window close runs a window state,
// then per record a read state, a divider start state and the 52-step serial
// divider, then the two totals through the divider. Peak reset sweeps the record
// RAM with a read and a write state per record. Record RAM needs a clearing pass
// over all 32 records after reset, with busy_o high. The receiver cannot stall.
`default_nettype none
module task_interrupt_load_profiler (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire tilp_pkg::req_t   req_i,
  output logic                  res_valid_o,
  output tilp_pkg::res_t        res_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i
);
  tilp_pkg::state_e state_q, state_d;
  tilp_pkg::req_t   req_q, req_d;
  tilp_pkg::res_t   res_d;
  tilp_pkg::rec_t   rd, wr;
  logic [31:0] cpt_q, tmask_q, imask_q;
  logic        clr_q;
  logic [5:0]  clr_cnt_q;
  logic [4:0]  idx_q, idx_d, raddr;
  logic        we;
  logic        valid_d;
  logic        running_q, running_d;
  logic [31:0] nested_q, nested_d, wstart_q, wstart_d, window_q, window_d;
  logic [15:0] tpeak_q, tpeak_d, ipeak_q, ipeak_d, tl_q, tl_d;
  logic [36:0] tsum_q, tsum_d, isum_q, isum_d;
  logic [31:0] elapsed, dur, net, mul_lo;
  logic [63:0] prod;
  logic        dgo;
  logic [51:0] dnum;
  logic        ddone;
  logic [15:0] dq;
  logic [15:0] lpk;
  tilp_pkg::rec_t wsel;

  assign raddr = (state_q == tilp_pkg::ST_IDLE) ? req_i.record_index : idx_q;
  assign wsel  = clr_q ? tilp_pkg::rec_t'('0) : wr;

  tilp_ram #(.Width(tilp_pkg::RecW), .Depth(tilp_pkg::Records)) u_rec (
    .clk_i  (clk_i),
    .we_i   (we | clr_q),
    .waddr_i(clr_q ? clr_cnt_q[4:0] : idx_q),
    .wdata_i(wsel),
    .raddr_i(raddr),
    .rdata_o(rd)
  );

  tilp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (dgo),
    .num_i (dnum),
    .den_i (window_q),
    .done_o(ddone),
    .quot_o(dq)
  );

  assign busy_o  = (state_q != tilp_pkg::ST_IDLE) || clr_q;
  assign elapsed = req_q.system_tick - wstart_q;
  assign prod    = elapsed * cpt_q;
  assign mul_lo  = prod[31:0];
  assign dur     = req_q.counter_now - req_q.start_count;
  assign net     = (dur > nested_q) ? dur - nested_q : 32'd0;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    idx_d     = idx_q;
    running_d = running_q;
    nested_d  = nested_q;
    wstart_d  = wstart_q;
    window_d  = window_q;
    tpeak_d   = tpeak_q;
    ipeak_d   = ipeak_q;
    tsum_d    = tsum_q;
    isum_d    = isum_q;
    tl_d      = tl_q;
    we        = 1'b0;
    wr        = rd;
    valid_d   = 1'b0;
    res_d     = '0;
    dgo       = 1'b0;
    dnum      = '0;
    lpk       = (dq > rd.record_load_peak) ? dq : rd.record_load_peak;
    case (state_q)
      tilp_pkg::ST_IDLE: begin
        if (start_i && !clr_q) begin
          req_d = req_i;
          idx_d = req_i.record_index;
          case (tilp_pkg::op_e'(req_i.opcode))
            tilp_pkg::OP_BEGIN, tilp_pkg::OP_END, tilp_pkg::OP_IRQ:
              state_d = tilp_pkg::ST_EVRD;
            tilp_pkg::OP_CLOSE: state_d = tilp_pkg::ST_CLMUL;
            tilp_pkg::OP_PEAKS: begin
              idx_d   = '0;
              state_d = tilp_pkg::ST_PEAK;
            end
            default: state_d = tilp_pkg::ST_IDLE;
          endcase
        end
      end
      tilp_pkg::ST_EVRD: begin
        state_d = tilp_pkg::ST_EVWR;
      end
      tilp_pkg::ST_EVWR: begin
        we = 1'b1;
        res_d.result_kind = tilp_pkg::KIND_EVENT;
        res_d.out_index   = idx_q;
        res_d.last        = 1'b1;
        case (tilp_pkg::op_e'(req_q.opcode))
          tilp_pkg::OP_BEGIN: begin
            if (rd.start_seen) wr.start_gap = req_q.counter_now - rd.start_stamp;
            if (rd.end_seen) wr.idle_gap = req_q.counter_now - rd.end_stamp;
            wr.start_stamp = req_q.counter_now;
            wr.start_seen  = 1'b1;
            nested_d  = '0;
            running_d = 1'b1;
          end
          tilp_pkg::OP_END: begin
            if (net > rd.max_duration) wr.max_duration = net;
            wr.accumulated_run = rd.accumulated_run + net;
            wr.end_stamp = req_q.counter_now;
            wr.end_seen  = 1'b1;
            running_d = 1'b0;
            nested_d  = '0;
            res_d.measured_time = net;
          end
          default: begin
            if (dur > rd.max_duration) wr.max_duration = dur;
            wr.accumulated_run = rd.accumulated_run + dur;
            if (running_q) nested_d = nested_q + dur;
            res_d.measured_time = dur;
          end
        endcase
        res_d.peak_time      = wr.max_duration;
        res_d.start_interval = wr.start_gap;
        res_d.idle_interval  = wr.idle_gap;
        valid_d = 1'b1;
        state_d = tilp_pkg::ST_IDLE;
      end
      tilp_pkg::ST_CLMUL: begin
        if (elapsed == '0) begin
          state_d = tilp_pkg::ST_IDLE;
        end else begin
          wstart_d = req_q.system_tick;
          window_d = mul_lo;
          idx_d    = '0;
          tsum_d   = '0;
          isum_d   = '0;
          state_d  = (mul_lo == '0) ? tilp_pkg::ST_IDLE : tilp_pkg::ST_CLRD;
        end
      end
      tilp_pkg::ST_CLRD: begin
        state_d = tilp_pkg::ST_CLDIV;
      end
      tilp_pkg::ST_CLDIV: begin
        dgo     = 1'b1;
        dnum    = {5'd0, rd.accumulated_run, 15'd0};
        state_d = tilp_pkg::ST_CLWR;
      end
      tilp_pkg::ST_CLWR: begin
        if (ddone) begin
          we = 1'b1;
          wr.record_load_peak = lpk;
          wr.accumulated_run  = '0;
          if (tmask_q[idx_q]) tsum_d = tsum_q + {5'd0, rd.accumulated_run};
          else if (imask_q[idx_q]) isum_d = isum_q + {5'd0, rd.accumulated_run};
          res_d.result_kind    = tilp_pkg::KIND_LOAD;
          res_d.out_index      = idx_q;
          res_d.measured_time  = rd.accumulated_run;
          res_d.peak_time      = rd.max_duration;
          res_d.start_interval = rd.start_gap;
          res_d.idle_interval  = rd.idle_gap;
          res_d.load           = dq;
          res_d.load_peak      = lpk;
          valid_d = 1'b1;
          idx_d   = idx_q + 5'd1;
          state_d = (idx_q == 5'(tilp_pkg::Records - 1)) ? tilp_pkg::ST_TDIV
                                                         : tilp_pkg::ST_CLRD;
        end
      end
      tilp_pkg::ST_TDIV: begin
        // idx_q is 0 on entry: start the task total, then the interrupt total
        if (idx_q == '0) begin
          dgo   = 1'b1;
          dnum  = {tsum_q, 15'd0};
          idx_d = 5'd1;
        end else if (ddone) begin
          tl_d    = dq;
          dgo     = 1'b1;
          dnum    = {isum_q, 15'd0};
          state_d = tilp_pkg::ST_IDIV;
        end
      end
      tilp_pkg::ST_IDIV: begin
        if (ddone) begin
          res_d.result_kind   = tilp_pkg::KIND_SUMMARY;
          res_d.load          = tl_q;
          res_d.load_peak     = (tl_q > tpeak_q) ? tl_q : tpeak_q;
          res_d.irq_load      = dq;
          res_d.irq_load_peak = (dq > ipeak_q) ? dq : ipeak_q;
          res_d.last          = 1'b1;
          tpeak_d = res_d.load_peak;
          ipeak_d = res_d.irq_load_peak;
          tl_d    = '0;
          idx_d   = '0;
          valid_d = 1'b1;
          state_d = tilp_pkg::ST_IDLE;
        end
      end
      tilp_pkg::ST_PEAK: begin
        state_d = tilp_pkg::ST_SUM;
      end
      tilp_pkg::ST_SUM: begin
        we = 1'b1;
        wr.max_duration = '0;
        if (tmask_q[idx_q] || imask_q[idx_q]) wr.record_load_peak = '0;
        tpeak_d = '0;
        ipeak_d = '0;
        idx_d   = idx_q + 5'd1;
        state_d = (idx_q == 5'(tilp_pkg::Records - 1)) ? tilp_pkg::ST_IDLE
                                                       : tilp_pkg::ST_PEAK;
      end
      default: state_d = tilp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tilp_pkg::ST_IDLE;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      cpt_q       <= 32'd1;
      tmask_q     <= '0;
      imask_q     <= '0;
      running_q   <= 1'b0;
      nested_q    <= '0;
      wstart_q    <= '0;
      tpeak_q     <= '0;
      ipeak_q     <= '0;
      res_valid_o <= 1'b0;
      idx_q       <= '0;
      tl_q        <= '0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      nested_q    <= nested_d;
      wstart_q    <= wstart_d;
      tpeak_q     <= tpeak_d;
      ipeak_q     <= ipeak_d;
      res_valid_o <= valid_d;
      idx_q       <= idx_d;
      tl_q        <= tl_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 6'd1;
        if (clr_cnt_q == 6'(tilp_pkg::Records - 1)) clr_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (tilp_pkg::cfg_e'(cfg_idx_i))
          tilp_pkg::CFG_CPT:   cpt_q   <= cfg_data_i;
          tilp_pkg::CFG_TMASK: tmask_q <= cfg_data_i;
          tilp_pkg::CFG_IMASK: imask_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    window_q <= window_d;
    tsum_q   <= tsum_d;
    isum_q   <= isum_d;
    res_o    <= res_d;
  end
endmodule
`default_nettype wire
